/* src/sparse_column_tie_rank_top_macros.svh */
`ifndef SPARSE_COLUMN_TIE_RANK_TOP_MACROS_SVH
`define SPARSE_COLUMN_TIE_RANK_TOP_MACROS_SVH

// same-cycle implication
`define STCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/stcr_pkg.sv */
package stcr_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ROWS_W      = 21;
  localparam int RANK_W      = 22;
  localparam int TIE_W       = 61;
  localparam int SQ_W        = 2 * ROWS_W;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 21'h100000;
  localparam logic [RANK_W-1:0] RANK_MAX   = {RANK_W{1'b1}};
  localparam logic [TIE_W-1:0]  TIE_MAX    = {TIE_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(MAX_ENTRIES);

  localparam logic REG_TOTAL_ROWS = 1'b0;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         empty_column;
    logic                         last;
  } in_item_t;

  typedef struct packed {
    logic [5:0]        entry_index;
    logic [RANK_W-1:0] doubled_rank;
    logic              entry_valid;
    logic [TIE_W-1:0]  tie_correction;
    logic              overflow;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [ROWS_W-1:0] operand;
  } cube_req_t;

  typedef struct packed {
    logic             done;
    logic [TIE_W-1:0] result;
  } cube_rsp_t;

  typedef enum logic [2:0] {
    CU_IDLE, CU_SQ, CU_LO, CU_HI, CU_FIN
  } cube_state_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_PREP, SQ_ZSTART, SQ_ZWAIT, SQ_ELOAD,
    SQ_EKEY, SQ_SCAN, SQ_RUN, SQ_RWAIT, SQ_OUT
  } seq_state_t;

endpackage

/* src/stcr_mem.sv */
module stcr_mem (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [stcr_pkg::IDX_W-1:0]             waddr,
  input  logic signed [stcr_pkg::VALUE_BITS-1:0] wdata,
  input  logic [stcr_pkg::IDX_W-1:0]             raddr,
  output logic signed [stcr_pkg::VALUE_BITS-1:0] rdata
);
  import stcr_pkg::*;

  logic signed [VALUE_BITS-1:0] mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/stcr_cube.sv */
module stcr_cube (
  input  logic                clk,
  input  logic                rst_n,
  input  stcr_pkg::cube_req_t req,
  output stcr_pkg::cube_rsp_t rsp
);
  import stcr_pkg::*;

  cube_state_t       state_r, state_nxt;
  logic [ROWS_W-1:0] t_r;
  logic [SQ_W-1:0]   sq_r, lo_r, hi_r, prod;
  logic [ROWS_W-1:0] mul_a;
  logic [63:0]       full;
  logic [TIE_W-1:0]  res_r;
  logic              done_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CU_IDLE: if (req.start) state_nxt = CU_SQ;
      CU_SQ:   state_nxt = CU_LO;
      CU_LO:   state_nxt = CU_HI;
      CU_HI:   state_nxt = CU_FIN;
      CU_FIN:  state_nxt = CU_IDLE;
      default: state_nxt = CU_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      CU_LO:   mul_a = sq_r[ROWS_W-1:0];
      CU_HI:   mul_a = sq_r[SQ_W-1:ROWS_W];
      default: mul_a = t_r;
    endcase
  end

  assign prod = mul_a * t_r;
  assign full = {1'b0, hi_r, {ROWS_W{1'b0}}} + {22'b0, lo_r} - {43'b0, t_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CU_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == CU_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == CU_IDLE && req.start) t_r <= req.operand;
    if (state_r == CU_SQ) sq_r <= prod;
    if (state_r == CU_LO) lo_r <= prod;
    if (state_r == CU_HI) hi_r <= prod;
    if (state_r == CU_FIN) res_r <= (full > {3'b0, TIE_MAX}) ? TIE_MAX : full[TIE_W-1:0];
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

/* src/sparse_column_tie_rank_top.sv */
// Collect phase: one beat per cycle while idle (in_stall is high in every other
// state); no result until a beat with last or empty_column.
// Rank phase per entry e: a scan of all n stored values through the value
// RAM, plus a pass through the shared cube multiplier when e opens a run.
// Synchronous active-low reset: idle, empty column, total_rows = 1048576.
module sparse_column_tie_rank_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stcr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stcr_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import stcr_pkg::*;

  seq_state_t              state_r, state_nxt;
  logic [ROWS_W-1:0]       rows_r;
  logic [CNT_W-1:0]        cnt_r, e_r, j_r, pj_r, lt_r, le_r;
  logic                    drop_r, empty_r, ovf_r, first_r, cmp_v_r;
  logic [ROWS_W-1:0]       nz_r;
  logic [TIE_W-1:0]        acc_r;
  logic signed [VALUE_BITS-1:0] ve_r, rdata;
  logic [IDX_W-1:0]        raddr;
  logic                    we, in_acc, out_acc, is_last, issue;
  logic [CNT_W-1:0]        run_t;
  logic [TIE_W:0]          acc_sum;
  logic [RANK_W:0]         dr_full;
  logic [RANK_W-1:0]       dr;
  out_item_t               out_r;
  logic                    out_v_r;
  cube_req_t               creq;
  cube_rsp_t               crsp;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TOTAL_ROWS) ? {11'b0, rows_r} : 32'b0;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_v_r && !out_stall;
  assign is_last = (e_r == cnt_r - 1'b1);
  assign issue   = (j_r < cnt_r);
  assign run_t   = le_r - lt_r;
  assign acc_sum = {1'b0, acc_r} + {1'b0, crsp.result};
  assign dr_full = {1'b0, nz_r, 1'b0} + {{(RANK_W+1-CNT_W){1'b0}}, lt_r}
                 + {{(RANK_W+1-CNT_W){1'b0}}, le_r} + {{RANK_W{1'b0}}, 1'b1};
  assign dr      = dr_full[RANK_W] ? RANK_MAX : dr_full[RANK_W-1:0];

  stcr_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_data.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  stcr_cube u_cube (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (in_acc && in_data.empty_column) state_nxt = SQ_ZSTART;
        else if (in_acc && in_data.last) state_nxt = SQ_PREP;
      end
      SQ_PREP:   state_nxt = SQ_ZSTART;
      SQ_ZSTART: state_nxt = SQ_ZWAIT;
      SQ_ZWAIT: begin
        if (crsp.done) state_nxt = empty_r ? SQ_OUT : SQ_ELOAD;
      end
      SQ_ELOAD:  state_nxt = SQ_EKEY;
      SQ_EKEY:   state_nxt = SQ_SCAN;
      SQ_SCAN: begin
        if (!issue && !cmp_v_r) state_nxt = SQ_RUN;
      end
      SQ_RUN:    state_nxt = first_r ? SQ_RWAIT : SQ_OUT;
      SQ_RWAIT: begin
        if (crsp.done) state_nxt = SQ_OUT;
      end
      SQ_OUT: begin
        if (out_acc) state_nxt = out_r.last_result ? SQ_IDLE : SQ_ELOAD;
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != SQ_IDLE);
    we           = (state_r == SQ_IDLE) && in_acc && !in_data.empty_column
                   && (cnt_r < CNT_FULL);
    raddr        = (state_r == SQ_SCAN) ? j_r[IDX_W-1:0] : e_r[IDX_W-1:0];
    creq.start   = (state_r == SQ_ZSTART) || (state_r == SQ_RUN && first_r);
    creq.operand = (state_r == SQ_RUN) ? {{(ROWS_W-CNT_W){1'b0}}, run_t} : nz_r;
    out_valid    = out_v_r;
    out_data     = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      rows_r  <= ROWS_RESET;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      empty_r <= 1'b0;
      acc_r   <= '0;
      out_v_r <= 1'b0;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && cfg_paddr[2] == REG_TOTAL_ROWS) begin
        rows_r <= cfg_pwdata[ROWS_W-1:0];
      end
      cmp_v_r <= (state_r == SQ_SCAN) && issue;
      unique case (state_r)
        SQ_IDLE: begin
          if (in_acc && in_data.empty_column) begin
            cnt_r   <= '0;
            drop_r  <= 1'b0;
            empty_r <= 1'b1;
          end else if (in_acc) begin
            if (cnt_r < CNT_FULL) cnt_r <= cnt_r + 1'b1;
            else drop_r <= 1'b1;
          end
        end
        SQ_ZWAIT: begin
          if (crsp.done) begin
            acc_r <= crsp.result;
            if (empty_r) out_v_r <= 1'b1;
          end
        end
        SQ_RUN: begin
          if (!first_r) out_v_r <= 1'b1;
        end
        SQ_RWAIT: begin
          if (crsp.done) begin
            acc_r   <= acc_sum[TIE_W] ? TIE_MAX : acc_sum[TIE_W-1:0];
            out_v_r <= 1'b1;
          end
        end
        SQ_OUT: begin
          if (out_acc) begin
            out_v_r <= 1'b0;
            if (out_r.last_result) begin
              cnt_r   <= '0;
              drop_r  <= 1'b0;
              empty_r <= 1'b0;
              acc_r   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      SQ_IDLE: begin
        if (in_acc && in_data.empty_column) nz_r <= rows_r;
        e_r <= '0;
      end
      SQ_PREP: begin
        nz_r  <= ({{(ROWS_W-CNT_W){1'b0}}, cnt_r} > rows_r) ? '0
                 : rows_r - {{(ROWS_W-CNT_W){1'b0}}, cnt_r};
        ovf_r <= drop_r || ({{(ROWS_W-CNT_W){1'b0}}, cnt_r} > rows_r);
      end
      SQ_ZWAIT: begin
        if (crsp.done && empty_r) begin
          out_r.entry_index    <= '0;
          out_r.doubled_rank   <= '0;
          out_r.entry_valid    <= 1'b0;
          out_r.tie_correction <= crsp.result;
          out_r.overflow       <= 1'b0;
          out_r.last_result    <= 1'b1;
        end
      end
      SQ_EKEY: begin
        ve_r    <= rdata;
        j_r     <= '0;
        lt_r    <= '0;
        le_r    <= '0;
        first_r <= 1'b1;
      end
      SQ_SCAN: begin
        if (issue) j_r <= j_r + 1'b1;
        pj_r <= j_r;
        if (cmp_v_r) begin
          if (rdata < ve_r) lt_r <= lt_r + 1'b1;
          if (rdata <= ve_r) le_r <= le_r + 1'b1;
          if (rdata == ve_r && pj_r < e_r) first_r <= 1'b0;
        end
      end
      SQ_RUN, SQ_RWAIT: begin
        out_r.entry_index    <= e_r[5:0];
        out_r.doubled_rank   <= dr;
        out_r.entry_valid    <= 1'b1;
        out_r.overflow       <= ovf_r;
        out_r.last_result    <= is_last;
        if (state_r == SQ_RWAIT) begin
          out_r.tie_correction <= (is_last) ?
            (acc_sum[TIE_W] ? TIE_MAX : acc_sum[TIE_W-1:0]) : '0;
        end else begin
          out_r.tie_correction <= is_last ? acc_r : '0;
        end
      end
      SQ_OUT: begin
        if (out_acc) e_r <= e_r + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* src/stcr_checker.sv */
`include "sparse_column_tie_rank_top_macros.svh"

module stcr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input stcr_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input stcr_pkg::out_item_t out_data
);
  import stcr_pkg::*;

  `STCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, $stable(out_data), "stalled beat changed")
  `STCR_ASSERT_NEXT(a_close_busy, in_valid && !in_stall && (in_data.last || in_data.empty_column), in_stall, "closing beat did not stall input")
  `STCR_ASSERT_NOW(a_out_busy, out_valid, in_stall, "input open while result pending")
  `STCR_ASSERT_NOW(a_empty_last, out_valid && !out_data.entry_valid, out_data.last_result, "no-entry result not last")
  `STCR_ASSERT_NOW(a_tie_last, out_valid && !out_data.last_result, out_data.tie_correction == '0, "tie on non-last result")

endmodule

bind sparse_column_tie_rank_top stcr_checker u_stcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/tb_sparse_column_tie_rank_top.sv */
`timescale 1ns / 100ps

module tb_sparse_column_tie_rank_top;
  import stcr_pkg::*;

  localparam logic [2:0] ADDR_TOTAL_ROWS = {2'b00, REG_TOTAL_ROWS} << 2;
  localparam int         IDLE_LIMIT      = 60000;
  localparam logic [31:0] KEY_FLIP       = 32'h8000_0000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sparse_column_tie_rank_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state
  logic [ROWS_W-1:0] rows_model;
  logic [31:0]       column_keys[$];
  bit                column_dropped;
  out_item_t         rank_queue[$];

  int fail_count = 0;
  int idle_cycles = 0;
  int beats_sent;
  int columns_closed;
  int ranks_checked = 0;
  int dropped_columns;
  bit stall_quiet;

  function automatic logic [63:0] cube_less_t(logic [63:0] t);
    logic [63:0] c;
    if (t < 2) return 0;
    c = t * t * t - t;
    return (c > 64'(TIE_MAX)) ? 64'(TIE_MAX) : c;
  endfunction

  function automatic void predict_ranks(in_item_t item);
    out_item_t   r;
    int          n;
    int          below;
    int          same;
    bit          first_of_run;
    bit          ovf;
    logic [63:0] zeros;
    logic [63:0] tie;
    logic [63:0] dr;
    if (item.empty_column) begin
      column_keys.delete();
      column_dropped = 0;
      r = '0;
      r.tie_correction = TIE_W'(cube_less_t(64'(rows_model)));
      r.last_result = 1'b1;
      rank_queue.push_back(r);
      columns_closed++;
      return;
    end
    if (column_keys.size() < MAX_ENTRIES) column_keys.push_back(item.value ^ KEY_FLIP);
    else column_dropped = 1;
    if (!item.last) return;
    n = column_keys.size();
    ovf = column_dropped || (n > rows_model);
    zeros = (n > rows_model) ? 0 : 64'(rows_model) - n;
    tie = cube_less_t(zeros);
    if (column_dropped) dropped_columns++;
    for (int i = 0; i < n; i++) begin
      below = 0;
      same = 0;
      first_of_run = 1;
      for (int j = 0; j < n; j++) begin
        if (column_keys[j] < column_keys[i]) below++;
        if (column_keys[j] == column_keys[i]) begin
          same++;
          if (j < i) first_of_run = 0;
        end
      end
      if (first_of_run) begin
        tie = tie + cube_less_t(same);
        if (tie > 64'(TIE_MAX)) tie = 64'(TIE_MAX);
      end
      dr = 2 * zeros + below + 1 + below + same;
      if (dr > 64'(RANK_MAX)) dr = 64'(RANK_MAX);
      r = '0;
      r.entry_index = 6'(i);
      r.doubled_rank = RANK_W'(dr);
      r.entry_valid = 1'b1;
      r.overflow = ovf;
      rank_queue.push_back(r);
    end
    if (n == 0) begin
      r = '0;
      r.overflow = ovf;
      rank_queue.push_back(r);
    end
    rank_queue[rank_queue.size()-1].tie_correction = TIE_W'(tie);
    rank_queue[rank_queue.size()-1].last_result = 1'b1;
    column_keys.delete();
    column_dropped = 0;
    columns_closed++;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rank_queue.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = rank_queue.pop_front();
        ranks_checked++;
        if (out_data.entry_index != want.entry_index)
          report_mismatch("entry_index", out_data.entry_index, want.entry_index);
        if (out_data.doubled_rank != want.doubled_rank)
          report_mismatch("doubled_rank", out_data.doubled_rank, want.doubled_rank);
        if (out_data.entry_valid != want.entry_valid)
          report_mismatch("entry_valid", out_data.entry_valid, want.entry_valid);
        if (out_data.tie_correction != want.tie_correction)
          report_mismatch("tie_correction", out_data.tie_correction, want.tie_correction);
        if (out_data.overflow != want.overflow)
          report_mismatch("overflow", out_data.overflow, want.overflow);
        if (out_data.last_result != want.last_result)
          report_mismatch("last_result", out_data.last_result, want.last_result);
      end
    end
  end

  // receiver stall: quiet stretches, short stalls, rare long ones
  always @(posedge clk) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (!rst_n || stall_quiet) out_stall <= 1'b0;
    else if (pick < 60) out_stall <= 1'b0;
    else if (pick < 97) out_stall <= 1'b1;
    else begin
      out_stall <= 1'b1;
      repeat ($urandom_range(10, 40)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("tb_sparse_column_tie_rank_top NOT OK");
      $finish;
    end
  end

  function automatic in_item_t make_beat(logic [31:0] v, logic empty, logic last);
    in_item_t b;
    b.value = v;
    b.empty_column = empty;
    b.last = last;
    return b;
  endfunction

  task automatic send_beat(in_item_t b);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap = (pick < 55) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    predict_ranks(b);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rank_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_total_rows(logic [31:0] rows);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_TOTAL_ROWS;
    cfg_pwdata <= rows;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rows_model = rows[ROWS_W-1:0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic send_column(int n, logic [31:0] pool);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      v = (pool == 0) ? $urandom() : 32'($urandom_range(0, pool)) - (pool >> 1);
      send_beat(make_beat(v, 1'b0, i == n - 1));
    end
  endtask

  task automatic test_value_extremes();
    send_beat(make_beat(32'h8000_0000, 1'b0, 1'b0));
    send_beat(make_beat(32'h7fff_ffff, 1'b0, 1'b0));
    send_beat(make_beat(32'h0001_0000, 1'b0, 1'b0));
    send_beat(make_beat(32'h7fff_ffff, 1'b0, 1'b0));
    send_beat(make_beat(32'hffff_ffff, 1'b0, 1'b1));
    send_beat(make_beat(32'h0000_0001, 1'b0, 1'b1));
  endtask

  task automatic test_empty_columns();
    send_beat(make_beat(32'hdead_beef, 1'b1, 1'b1));
    send_beat(make_beat(32'h1234_5678, 1'b0, 1'b0));
    send_beat(make_beat(32'h0000_0000, 1'b1, 1'b0));
    send_beat(make_beat(32'h0000_0005, 1'b0, 1'b1));
  endtask

  task automatic test_row_overflow();
    write_total_rows(1);
    send_column(3, 4);
    send_beat(make_beat(32'h0, 1'b1, 1'b0));
    write_total_rows(3);
    send_column(3, 2);
  endtask

  task automatic test_storage_full();
    write_total_rows(100);
    send_column(MAX_ENTRIES + 2, 40);
  endtask

  task automatic test_random_columns();
    int target;
    int pick;
    logic [31:0] rows;
    target = beats_sent + 110;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        pick = $urandom_range(0, 4);
        rows = (pick == 0) ? 1 : (pick == 1) ? 1048576 : (pick == 2) ? $urandom_range(1, 8)
             : $urandom_range(1, 1048576);
        write_total_rows(rows);
        stall_quiet = $urandom_range(0, 3) == 0;
      end else if (pick < 18) begin
        send_beat(make_beat($urandom(), 1'b1, $urandom_range(0, 1)));
      end else if (pick < 22) begin
        send_column($urandom_range(1, 4), 0);
        send_beat(make_beat($urandom(), 1'b1, 1'b0));
      end else begin
        send_column($urandom_range(1, 8), ($urandom_range(0, 1) != 0) ? 6 : 0);
      end
      if (pick == 50) wait_drained();
    end
    stall_quiet = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    rows_model = ROWS_RESET;
    column_dropped = 0;
    beats_sent = 0;
    columns_closed = 0;
    dropped_columns = 0;
    stall_quiet = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_value_extremes();
    test_empty_columns();
    wait_drained();
    test_row_overflow();
    test_storage_full();
    write_total_rows(1048576);
    send_column(4, 2);
    test_random_columns();
    wait_drained();
    repeat (100) @(posedge clk);
    $display("run: %0d beats in, %0d columns closed, %0d rank beats checked",
             beats_sent, columns_closed, ranks_checked);
    $display("%0d columns hit storage drop; row counts from 1 to 1048576", dropped_columns);
    if (fail_count == 0 && rank_queue.size() == 0) begin
      $display("tb_sparse_column_tie_rank_top OK");
    end else begin
      $display("tb_sparse_column_tie_rank_top NOT OK");
    end
    $finish;
  end

endmodule
